// ===== sv/rk4_oscillator_stepper_unit_assert.svh =====
// ----------------------------------------------------------------------------
// RK4 oscillator stepper assertion macros
// Concurrent check macros shared by the RTL files. They are empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RK4_OSCILLATOR_STEPPER_UNIT_ASSERT_SVH
`define RK4_OSCILLATOR_STEPPER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define RK4OS_ASSERT_NOW(label, a_clk, a_rst_n, ante, cons, msg) \
    label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RK4OS_ASSERT_NEXT(label, a_clk, a_rst_n, ante, cons, msg) \
    label: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RK4OS_ASSERT_NOW(label, a_clk, a_rst_n, ante, cons, msg)
`define RK4OS_ASSERT_NEXT(label, a_clk, a_rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/rk4os_pkg.sv =====
// ----------------------------------------------------------------------------
// RK4 oscillator stepper package
// Widths, codes, payload types and the sequencer states of the stepper.
// ----------------------------------------------------------------------------
package rk4os_pkg;

    // Q16.16 state words and the wider internal datapath for stage values.
    localparam int DATA_W  = 32;
    localparam int DP_W    = 36;
    localparam int EXT_W   = DP_W - DATA_W;
    localparam int Q_FRAC  = 16;
    localparam int STEP_W  = 16;
    localparam int MUL_W   = DP_W + STEP_W + 1;

    // Eight products per step, two per RK4 stage.
    localparam int N_OPS   = 8;
    localparam int OP_W    = $clog2(N_OPS);
    localparam int CNT_W   = OP_W + 1;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(N_OPS);

    // Divide by six: halve, then divide by three a chunk of bits per cycle.
    localparam int DIV_CHUNK  = 9;
    localparam int DIV_STEPS  = DP_W / DIV_CHUNK;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
    localparam int DIV_LANES  = 2;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE = REG_IDX_W'(0);
    localparam logic [STEP_W-1:0] STEP_SIZE_RESET = STEP_W'(6554);

    // Request type codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] pos_in;
        logic signed [DATA_W-1:0] vel_in;
        logic signed [DATA_W-1:0] time_in;
    } rk4os_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_out;
        logic signed [DATA_W-1:0] vel_out;
        logic signed [DATA_W-1:0] time_out;
    } rk4os_res_t;

    // Quotient of one lane of the divider as sign and magnitude.
    typedef struct packed {
        logic            neg;
        logic [DP_W-1:0] mag;
    } rk4os_quo_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PUBLISH
    } rk4os_state_t;

endpackage

// ===== sv/rk4os_hmul.sv =====
// ----------------------------------------------------------------------------
// RK4 oscillator stepper step multiplier
// Shared unit forming h * x in Q16.16, rounded toward minus infinity, with a
// registered product.
// ----------------------------------------------------------------------------
module rk4os_hmul (
    input  logic                                 clk,
    input  logic signed [rk4os_pkg::DP_W-1:0]    operand,
    input  logic        [rk4os_pkg::STEP_W-1:0]  step_size,
    output logic signed [rk4os_pkg::DP_W-1:0]    product
);
    import rk4os_pkg::*;

    logic signed [MUL_W-1:0] full;
    logic signed [DP_W-1:0]  prod_next;
    logic signed [DP_W-1:0]  prod_reg;

    // Taking the upper bits of the exact product is an arithmetic shift, which
    // rounds toward minus infinity. The result always fits the datapath.
    assign full      = operand * $signed({1'b0, step_size});
    assign prod_next = full[Q_FRAC+DP_W-1:Q_FRAC];

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

// ===== sv/rk4os_div6.sv =====
// ----------------------------------------------------------------------------
// RK4 oscillator stepper divide-by-six unit
// Two lanes dividing the weighted stage sums by six with truncation toward
// zero, a chunk of quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "rk4_oscillator_stepper_unit_assert.svh"

module rk4os_div6 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rk4os_pkg::DP_W-1:0]  sum_p,
    input  logic signed [rk4os_pkg::DP_W-1:0]  sum_v,
    output logic                               done,
    output rk4os_pkg::rk4os_quo_t              quo_p,
    output rk4os_pkg::rk4os_quo_t              quo_v
);
    import rk4os_pkg::*;

    logic signed [DP_W-1:0]  sum_in    [DIV_LANES];
    logic [DP_W-1:0]         dvd_reg   [DIV_LANES];
    logic [DP_W-1:0]         dvd_next  [DIV_LANES];
    logic [DP_W-1:0]         quo_reg   [DIV_LANES];
    logic [DP_W-1:0]         quo_next  [DIV_LANES];
    logic [1:0]              rem_reg   [DIV_LANES];
    logic [1:0]              rem_next  [DIV_LANES];
    logic                    neg_reg   [DIV_LANES];
    logic                    neg_next  [DIV_LANES];
    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [DIV_CNT_W-1:0]    cnt_reg;
    logic [DIV_CNT_W-1:0]    cnt_next;

    // Restoring division by three over one chunk, most significant bit first.
    // Returns the new remainder above the quotient bits.
    function automatic logic [DIV_CHUNK+1:0] div3_chunk(
        input logic [1:0]           rem_in,
        input logic [DIV_CHUNK-1:0] bits
    );
        logic [1:0]           r;
        logic [2:0]           t;
        logic [DIV_CHUNK-1:0] q;
        r = rem_in;
        q = '0;
        for (int i = DIV_CHUNK - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= 3'd3)
            begin
                q[i] = 1'b1;
                r    = 2'(t - 3'd3);
            end
            else
            begin
                r = t[1:0];
            end
        end
        return {r, q};
    endfunction

    assign sum_in[0] = sum_p;
    assign sum_in[1] = sum_v;

    always_comb
    begin
        logic [DIV_CHUNK+1:0] chunk_res;
        logic [DP_W-1:0]      mag;
        for (int l = 0; l < DIV_LANES; l++)
        begin
            dvd_next[l] = dvd_reg[l];
            quo_next[l] = quo_reg[l];
            rem_next[l] = rem_reg[l];
            neg_next[l] = neg_reg[l];
            chunk_res   = div3_chunk(rem_reg[l], dvd_reg[l][DP_W-1 -: DIV_CHUNK]);
            mag         = sum_in[l][DP_W-1] ? DP_W'(-sum_in[l]) : DP_W'(sum_in[l]);
            if (start)
            begin
                // Dividing the magnitude by two first leaves a divide by three.
                neg_next[l] = sum_in[l][DP_W-1];
                dvd_next[l] = {1'b0, mag[DP_W-1:1]};
                rem_next[l] = '0;
            end
            else if (busy_reg)
            begin
                dvd_next[l] = dvd_reg[l] << DIV_CHUNK;
                quo_next[l] = {quo_reg[l][DP_W-DIV_CHUNK-1:0], chunk_res[DIV_CHUNK-1:0]};
                rem_next[l] = chunk_res[DIV_CHUNK+1 -: 2];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            dvd_reg[l] <= dvd_next[l];
            quo_reg[l] <= quo_next[l];
            rem_reg[l] <= rem_next[l];
            neg_reg[l] <= neg_next[l];
        end
    end

    assign done      = done_reg;
    assign quo_p.neg = neg_reg[0];
    assign quo_p.mag = quo_reg[0];
    assign quo_v.neg = neg_reg[1];
    assign quo_v.mag = quo_reg[1];

    `RK4OS_ASSERT_NOW(a_start_when_free, clk, rst_n, start, !busy_reg, "division started while busy")
    `RK4OS_ASSERT_NOW(a_done_after_busy, clk, rst_n, done_reg, !busy_reg && !start, "done overlaps a division")

endmodule

// ===== sv/rk4_oscillator_stepper_unit.sv =====
// ----------------------------------------------------------------------------
// RK4 oscillator stepper
// Fourth-order Runge-Kutta step of the harmonic oscillator in Q16.16, with
// one shared step multiplier, a divide-by-six unit and a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                   Payload
// req      in         req_valid / req_ready       rk4os_req_t
// res      out        res_valid / res_ready       rk4os_res_t
// cfg      in         psel, penable, pwrite       step_size at byte address 0
//
// A load request passes from idle through the publish state back to idle.
// A step request runs the eight dependent products through the shared
// multiplier, then the divide-by-six unit, writes the state as the division
// finishes, publishes the result and returns to idle.
// Reset clears the state to zero and the step size to 6554; no clearing pass.
// The result register lets the next request in while a result waits; a
// finished request holds in the publish state until that register is free.
// ----------------------------------------------------------------------------
`include "rk4_oscillator_stepper_unit_assert.svh"

module rk4_oscillator_stepper_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  rk4os_pkg::rk4os_req_t              req_data,
    output logic                               res_valid,
    input  logic                               res_ready,
    output rk4os_pkg::rk4os_res_t              res_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rk4os_pkg::PADDR_W-1:0]      paddr,
    input  logic [rk4os_pkg::PDATA_W-1:0]      pwdata,
    output logic [rk4os_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import rk4os_pkg::*;

    localparam logic signed [DP_W:0] SAT_HI = {{(EXT_W+2){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [DP_W:0] SAT_LO = {{(EXT_W+2){1'b1}}, {(DATA_W-1){1'b0}}};

    rk4os_state_t             state_reg;
    rk4os_state_t             state_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [STEP_W-1:0]        step_size_reg;
    logic [STEP_W-1:0]        step_size_next;
    logic signed [DATA_W-1:0] pos_reg;
    logic signed [DATA_W-1:0] pos_next;
    logic signed [DATA_W-1:0] vel_reg;
    logic signed [DATA_W-1:0] vel_next;
    logic signed [DATA_W-1:0] time_reg;
    logic signed [DATA_W-1:0] time_next;
    logic signed [DP_W-1:0]   mp_reg;
    logic signed [DP_W-1:0]   mp_next;
    logic signed [DP_W-1:0]   mv_reg;
    logic signed [DP_W-1:0]   mv_next;
    logic signed [DP_W-1:0]   sp_reg;
    logic signed [DP_W-1:0]   sp_next;
    logic signed [DP_W-1:0]   sv_reg;
    logic signed [DP_W-1:0]   sv_next;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    rk4os_res_t               res_data_reg;
    rk4os_res_t               res_data_next;

    logic                     req_accept;
    logic                     cfg_write;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     mul_upd;
    logic                     div_start;
    logic                     upd_en;
    logic                     publish;
    logic [OP_W-1:0]          issue_op;
    logic [OP_W-1:0]          upd_op;
    logic [1:0]               upd_stage;
    logic                     issue_p;
    logic                     upd_p;
    logic signed [DP_W-1:0]   mul_operand;
    logic signed [DP_W-1:0]   product;
    logic signed [DP_W-1:0]   k_w;
    logic signed [DP_W-1:0]   k_mid;
    logic signed [DP_W-1:0]   p_ext;
    logic signed [DP_W-1:0]   v_ext;
    logic signed [DP_W:0]     pos_sum;
    logic signed [DP_W:0]     vel_sum;
    logic signed [DP_W:0]     time_sum;
    logic                     div_done;
    rk4os_quo_t               quo_p;
    rk4os_quo_t               quo_v;

    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [DP_W:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            return SAT_LO[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        step_size_next = step_size_reg;
        if (cfg_write && reg_idx == REG_STEP_SIZE)
        begin
            step_size_next = pwdata[STEP_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_STEP_SIZE)
        begin
            prdata = {{(PDATA_W-STEP_W){1'b0}}, step_size_reg};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign req_accept = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = (req_data.req_type == REQ_STEP) ? ST_MUL : ST_PUBLISH;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        mul_upd   = 1'b0;
        div_start = 1'b0;
        upd_en    = 1'b0;
        publish   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_MUL:
            begin
                mul_upd = (cnt_reg != '0);
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                upd_en = div_done;
            end
            ST_PUBLISH:
            begin
                publish = !res_valid_reg || res_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Product schedule
    // ------------------------------------------------------------------
    // Each stage needs h*mv for position and h*(-mp) for velocity. The order
    // alternates between stages so that the midpoint each product needs is already
    // written when it issues, keeping the multiplier busy every cycle.
    assign issue_op  = cnt_reg[OP_W-1:0];
    assign issue_p   = ~(issue_op[0] ^ issue_op[1]);
    assign upd_op    = OP_W'(cnt_reg - CNT_W'(1));
    assign upd_stage = upd_op[OP_W-1:1];
    assign upd_p     = ~(upd_op[0] ^ upd_op[1]);

    assign mul_operand = issue_p ? mv_reg : -mp_reg;

    rk4os_hmul u_hmul (
        .clk       (clk),
        .operand   (mul_operand),
        .step_size (step_size_reg),
        .product   (product)
    );

    // The middle two stages count twice in the weighted sum. Midpoints use
    // half the stage value, except the last one which uses all of it.
    assign k_w   = (upd_stage == 2'd1 || upd_stage == 2'd2) ? (product <<< 1) : product;
    assign k_mid = (upd_stage == 2'd2) ? product : (product >>> 1);
    assign p_ext = {{EXT_W{pos_reg[DATA_W-1]}}, pos_reg};
    assign v_ext = {{EXT_W{vel_reg[DATA_W-1]}}, vel_reg};

    rk4os_div6 u_div6 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum_p (sp_reg),
        .sum_v (sv_reg),
        .done  (div_done),
        .quo_p (quo_p),
        .quo_v (quo_v)
    );

    assign pos_sum  = quo_p.neg ? ({p_ext[DP_W-1], p_ext} - {1'b0, quo_p.mag})
                                : ({p_ext[DP_W-1], p_ext} + {1'b0, quo_p.mag});
    assign vel_sum  = quo_v.neg ? ({v_ext[DP_W-1], v_ext} - {1'b0, quo_v.mag})
                                : ({v_ext[DP_W-1], v_ext} + {1'b0, quo_v.mag});
    assign time_sum = {{(EXT_W+1){time_reg[DATA_W-1]}}, time_reg}
                    + {{(DP_W+1-STEP_W){1'b0}}, step_size_reg};

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        time_next = time_reg;
        mp_next   = mp_reg;
        mv_next   = mv_reg;
        sp_next   = sp_reg;
        sv_next   = sv_reg;
        cnt_next  = cnt_reg;

        if (req_accept)
        begin
            if (req_data.req_type == REQ_LOAD)
            begin
                pos_next  = req_data.pos_in;
                vel_next  = req_data.vel_in;
                time_next = req_data.time_in;
            end
            else
            begin
                mp_next  = p_ext;
                mv_next  = v_ext;
                sp_next  = '0;
                sv_next  = '0;
                cnt_next = '0;
            end
        end

        if (state_reg == ST_MUL)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (mul_upd)
        begin
            if (upd_p)
            begin
                sp_next = sp_reg + k_w;
                if (upd_stage != 2'd3)
                begin
                    mp_next = p_ext + k_mid;
                end
            end
            else
            begin
                sv_next = sv_reg + k_w;
                if (upd_stage != 2'd3)
                begin
                    mv_next = v_ext + k_mid;
                end
            end
        end

        if (upd_en)
        begin
            pos_next  = sat_q(pos_sum);
            vel_next  = sat_q(vel_sum);
            time_next = sat_q(time_sum);
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (publish)
        begin
            res_valid_next         = 1'b1;
            res_data_next.pos_out  = pos_reg;
            res_data_next.vel_out  = vel_reg;
            res_data_next.time_out = time_reg;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            step_size_reg <= STEP_SIZE_RESET;
            pos_reg       <= '0;
            vel_reg       <= '0;
            time_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            step_size_reg <= step_size_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            time_reg      <= time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg       <= mp_next;
        mv_reg       <= mv_next;
        sp_reg       <= sp_next;
        sv_reg       <= sv_next;
        res_data_reg <= res_data_next;
    end

    `RK4OS_ASSERT_NOW(a_mul_count_range, clk, rst_n, state_reg == ST_MUL, cnt_reg <= MUL_LAST, "product counter overran")
    `RK4OS_ASSERT_NOW(a_div_done_waited, clk, rst_n, div_done, state_reg == ST_DIV_WAIT, "division finished outside its wait")
    `RK4OS_ASSERT_NEXT(a_load_taken, clk, rst_n, req_accept && req_data.req_type == REQ_LOAD, state_reg == ST_PUBLISH && pos_reg == $past(req_data.pos_in), "load request not taken")
    `RK4OS_ASSERT_NEXT(a_time_advances, clk, rst_n, upd_en, time_reg >= $past(time_reg), "time moved backwards on a step")

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// RK4 oscillator stepper testbench
// Drives load and step requests through the valid/ready request channel and checks
// every result against a Q16.16 model of the RK4 step kept in the bench or, for a
// directed row, against its typed result. The step size is changed over the APB
// port between phases, and read back. A short table of directed requests runs
// first, then random load-and-step sequences with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import rk4os_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 125;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct {
        bit               set_h;
        logic [STEP_W-1:0] h;
        rk4os_req_t       req;
        bit               known;
        rk4os_res_t       res;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    rk4os_req_t           req_data;
    logic                 res_valid;
    logic                 res_ready;
    rk4os_res_t           res_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Bench copy of the oscillator state and the step size register.
    logic signed [DATA_W-1:0] osc_pos;
    logic signed [DATA_W-1:0] osc_vel;
    logic signed [DATA_W-1:0] osc_time;
    logic [STEP_W-1:0]        step_h;

    rk4os_res_t predicted_q[$];
    dir_row_t   dir_rows[$];

    // Typed expectation travelling with the request being offered.
    bit         row_known;
    rk4os_res_t row_res;

    int errors;
    int quiet_cycles;
    int idle_pct;
    int n_loads;
    int n_steps;
    int n_checked;
    int n_sat;
    int n_sizes;

    rk4_oscillator_stepper_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    function automatic longint scale_by_h(input longint x);
        longint h64;
        h64 = longint'(step_h);
        // Arithmetic shift of a signed value floors, as the datapath does.
        return (x * h64) >>> Q_FRAC;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input longint x);
        if (x > longint'(Q_MAX))
        begin
            n_sat++;
            return Q_MAX;
        end
        if (x < longint'(Q_MIN))
        begin
            n_sat++;
            return Q_MIN;
        end
        return x[DATA_W-1:0];
    endfunction

    // One RK4 step of pos' = vel, vel' = -pos, or a load of a new state.
    function automatic rk4os_res_t rk4_predict(input rk4os_req_t r);
        rk4os_res_t o;
        longint p;
        longint v;
        longint k1p, k1v, k2p, k2v, k3p, k3v, k4p, k4v;
        longint mp, mv, sp, sv;
        if (r.req_type == REQ_LOAD)
        begin
            osc_pos  = r.pos_in;
            osc_vel  = r.vel_in;
            osc_time = r.time_in;
        end
        else
        begin
            p = longint'(osc_pos);
            v = longint'(osc_vel);
            k1p = scale_by_h(v);
            k1v = scale_by_h(-p);
            mp  = p + (k1p >>> 1);
            mv  = v + (k1v >>> 1);
            k2p = scale_by_h(mv);
            k2v = scale_by_h(-mp);
            mp  = p + (k2p >>> 1);
            mv  = v + (k2v >>> 1);
            k3p = scale_by_h(mv);
            k3v = scale_by_h(-mp);
            mp  = p + k3p;
            mv  = v + k3v;
            k4p = scale_by_h(mv);
            k4v = scale_by_h(-mp);
            sp  = k1p + 2 * k2p + 2 * k3p + k4p;
            sv  = k1v + 2 * k2v + 2 * k3v + k4v;
            // Signed division truncates toward zero.
            osc_pos  = clamp32(p + sp / 6);
            osc_vel  = clamp32(v + sv / 6);
            osc_time = clamp32(longint'(osc_time) + longint'({48'd0, step_h}));
        end
        o.pos_out  = osc_pos;
        o.vel_out  = osc_vel;
        o.time_out = osc_time;
        return o;
    endfunction

    // Request and result monitor; values are sampled as they stood before the edge.
    always @(posedge clk)
    begin
        rk4os_res_t want;
        if (rst_n)
        begin
            quiet_cycles++;
            if (req_valid && req_ready)
            begin
                quiet_cycles = 0;
                if (req_data.req_type == REQ_LOAD)
                    n_loads++;
                else
                    n_steps++;
                want = rk4_predict(req_data);
                if (row_known)
                    want = row_res;
                predicted_q.push_back(want);
            end
            if (res_valid && res_ready)
            begin
                quiet_cycles = 0;
                if (predicted_q.size() == 0)
                begin
                    $error("result with no request outstanding: pos %0d vel %0d time %0d",
                           res_data.pos_out, res_data.vel_out, res_data.time_out);
                    errors++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    n_checked++;
                    if (res_data.pos_out !== want.pos_out)
                    begin
                        $error("pos_out expected %0d got %0d", want.pos_out, res_data.pos_out);
                        errors++;
                    end
                    if (res_data.vel_out !== want.vel_out)
                    begin
                        $error("vel_out expected %0d got %0d", want.vel_out, res_data.vel_out);
                        errors++;
                    end
                    if (res_data.time_out !== want.time_out)
                    begin
                        $error("time_out expected %0d got %0d", want.time_out,
                               res_data.time_out);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls in bursts, none once idle_pct drops to zero.
    initial
    begin
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 99) < idle_pct)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Offer one request and hold it until it is accepted.
    task automatic send_req(input rk4os_req_t r, input bit known, input rk4os_res_t r_exp);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        row_known <= known;
        row_res   <= r_exp;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    task automatic drain;
        req_valid <= 1'b0;
        row_known <= 1'b0;
        @(posedge clk);
        while (predicted_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the step size with the block idle, then read it back.
    task automatic set_step_size(input logic [STEP_W-1:0] h);
        logic [PDATA_W-1:0] word;
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        word = $urandom;
        word[STEP_W-1:0] = h;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STEP_SIZE, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        step_h = h;
        n_sizes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[STEP_W-1:0] !== step_h)
        begin
            $error("step_size read back expected %0d got %0d", step_h, prdata[STEP_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void add_row(input bit set_h, input logic [STEP_W-1:0] h,
                                    input logic rt, input logic [31:0] p,
                                    input logic [31:0] v, input logic [31:0] t,
                                    input bit known, input logic [31:0] ep,
                                    input logic [31:0] ev, input logic [31:0] et);
        dir_row_t row;
        row.set_h        = set_h;
        row.h            = h;
        row.req.req_type = rt;
        row.req.pos_in   = p;
        row.req.vel_in   = v;
        row.req.time_in  = t;
        row.known        = known;
        row.res.pos_out  = ep;
        row.res.vel_out  = ev;
        row.res.time_out = et;
        dir_rows.push_back(row);
    endfunction

    // Random Q16.16 word: full range, small magnitude, or close to a limit.
    function automatic logic [31:0] rand_word(input int mode);
        int s;
        case (mode)
            1:
            begin
                s = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
                return s;
            end
            2:
            begin
                if ($urandom_range(0, 1) == 0)
                    return Q_MAX - $urandom_range(0, 32'h0001_FFFF);
                return Q_MIN + $urandom_range(0, 32'h0001_FFFF);
            end
            3:
                return 32'h7FFF_0000 + $urandom_range(0, 32'h0000_FFFF);
            default:
                return $urandom;
        endcase
    endfunction

    initial
    begin
        rk4os_req_t r;
        rk4os_res_t none;
        logic [STEP_W-1:0] phase_h [N_PHASES];
        int phase_idle [N_PHASES];
        int sent;
        int run;
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        row_known = 1'b0;
        row_res   = '0;
        none      = '0;
        errors    = 0;
        idle_pct  = 20;
        n_sizes   = 1;
        osc_pos   = '0;
        osc_vel   = '0;
        osc_time  = '0;
        step_h    = STEP_SIZE_RESET;

        // Directed table. Typed results are the ones that can be read off directly.
        add_row(0, 0, REQ_STEP, 0, 0, 0, 1, 0, 0, 32'd6554);
        add_row(0, 0, REQ_LOAD, Q_MAX, Q_MIN, 0, 1, Q_MAX, Q_MIN, 0);
        add_row(0, 0, REQ_LOAD, Q_MIN, Q_MAX, Q_MIN, 1, Q_MIN, Q_MAX, Q_MIN);
        // A step of size zero leaves the whole state alone.
        add_row(1, 16'd0, REQ_STEP, 0, 0, 0, 1, Q_MIN, Q_MAX, Q_MIN);
        add_row(1, 16'hFFFF, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_LOAD, 32'h0001_0000, 0, 32'h7FFF_0000, 1,
                32'h0001_0000, 0, 32'h7FFF_0000);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 16'd1, REQ_LOAD, 0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 1, 0, 0, 32'd1);
        add_row(0, 0, REQ_LOAD, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_0000, 1,
                32'd1, 32'hFFFF_FFFF, 32'hFFFF_0000);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 16'd6554, REQ_LOAD, 32'h0001_0000, 0, Q_MIN, 1, 32'h0001_0000, 0, Q_MIN);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        // Fields of a step request are ignored whatever they hold.
        add_row(0, 0, REQ_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(0, 0, REQ_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 1,
                32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1,
                32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
        add_row(1, 16'h8000, REQ_STEP, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, REQ_LOAD, 0, 0, Q_MIN, 1, 0, 0, Q_MIN);
        add_row(0, 0, REQ_STEP, 0, 0, 0, 1, 0, 0, 32'h8000_8000);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_h)
                set_step_size(dir_rows[i].h);
            send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);
        end

        phase_h    = '{16'd1, 16'hFFFF, 16'd0, 16'(($urandom)), 16'd6554,
                       16'(($urandom_range(2, 255))), 16'(($urandom)), 16'd3277};
        phase_idle = '{25, 50, 0, 30, 40, 15, 30, 0};

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_step_size(phase_h[ph]);
            idle_pct = phase_idle[ph];
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: any request type with any content.
                    r.req_type = 1'($urandom_range(0, 1));
                    r.pos_in   = $urandom;
                    r.vel_in   = $urandom;
                    r.time_in  = $urandom;
                    send_req(r, 0, none);
                    sent++;
                end
                else
                begin
                    r.req_type = REQ_LOAD;
                    r.pos_in   = rand_word($urandom_range(0, 2));
                    r.vel_in   = rand_word($urandom_range(0, 2));
                    r.time_in  = rand_word($urandom_range(0, 3));
                    send_req(r, 0, none);
                    sent++;
                    run = $urandom_range(1, 24);
                    for (int k = 0; k < run; k++)
                    begin
                        r.req_type = REQ_STEP;
                        r.pos_in   = $urandom;
                        r.vel_in   = $urandom;
                        r.time_in  = $urandom;
                        send_req(r, 0, none);
                        sent++;
                    end
                end
                // Mid phase 3, hold the sender until the result queue is empty.
                if (ph == 3 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 26)
                    drain();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d load and %0d step requests under %0d step sizes,",
                 n_loads, n_steps, n_sizes);
        $display("%0d results checked, %0d predicted state words clamped to the limits.",
                 n_checked, n_sat);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rk4os_pkg.sv
sv/rk4os_hmul.sv
sv/rk4os_div6.sv
sv/rk4_oscillator_stepper_unit.sv
tb/testbench.sv
